@@ src/twsg_pkg.sv @@
package twsg_pkg;

    // Fixed field widths.
    localparam int IN_IDX_W = 16;
    localparam int CNT_W    = 17;
    localparam int AMP_W    = 16;
    localparam int MAG_W    = 15;
    localparam int VAL_W    = 24;
    localparam int OUT_W    = 32;
    localparam int PROD_W   = AMP_W + VAL_W;

    // Tangent divider: quotient bits, steps per stage and stage count.
    localparam int QUO_W      = 24;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;

    // Pi/2 in Q31, and the ROM entry ceiling.
    localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
    localparam logic [63:0] ROM_MAX     = 64'd32767;

    // Tangent clamp, about 256.0 in Q8.15.
    localparam logic signed [VAL_W-1:0] TAN_LIMIT = 24'sd8388607;

    // Waveform function codes.
    localparam logic [1:0] FUNC_SIN = 2'd0;
    localparam logic [1:0] FUNC_COS = 2'd1;
    localparam logic [1:0] FUNC_TAN = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_PHASE_STEP   = 2'd0;
    localparam logic [1:0] REG_AMPLITUDE    = 2'd1;
    localparam logic [1:0] REG_WAVE_FUNC    = 2'd2;
    localparam logic [1:0] REG_SAMPLE_COUNT = 2'd3;

    // Sine and cosine magnitudes with signs, as read from the ROM.
    typedef struct packed {
        logic             s_neg;
        logic [MAG_W-1:0] s_mag;
        logic             c_neg;
        logic [MAG_W-1:0] c_mag;
        logic             last;
    } trig_t;

    // Trig operands plus the tangent quotient magnitude.
    typedef struct packed {
        trig_t            trig;
        logic             sat;
        logic [QUO_W-1:0] quo;
    } tan_t;

    // One pair of Taylor terms: term * x^2 in Q31.
    function automatic logic [63:0] sq_step(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 31;
        t = (t * x) >> 31;
        return t;
    endfunction

    // Subtraction that stops at zero.
    function automatic logic [63:0] sub_floor(input logic [63:0] a, input logic [63:0] b);
        return (b <= a) ? (a - b) : 64'd0;
    endfunction

    // Quarter-wave entry k: round(32767 * sin(k * pi / 2 / 2^(table_bits-2))),
    // evaluated by an integer series in Q31. Used at elaboration only.
    function automatic logic [MAG_W-1:0] rom_entry(input int unsigned k,
                                                   input int unsigned table_bits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = (64'(k) * HALF_PI_Q31) >> (table_bits - 2);
        sum  = x;
        term = sq_step(x, x) / 64'd6;
        sum  = sub_floor(sum, term);
        term = sq_step(term, x) / 64'd20;
        sum  = sum + term;
        term = sq_step(term, x) / 64'd42;
        sum  = sub_floor(sum, term);
        term = sq_step(term, x) / 64'd72;
        sum  = sum + term;
        term = sq_step(term, x) / 64'd110;
        sum  = sub_floor(sum, term);
        term = sq_step(term, x) / 64'd156;
        sum  = sum + term;
        term = sq_step(term, x) / 64'd210;
        sum  = sub_floor(sum, term);
        term = sq_step(term, x) / 64'd272;
        sum  = sum + term;
        term = sq_step(term, x) / 64'd342;
        sum  = sub_floor(sum, term);
        term = sq_step(term, x) / 64'd420;
        sum  = sum + term;
        v = (sum * ROM_MAX + (64'd1 << 30)) >> 31;
        if (v > ROM_MAX) begin
            v = ROM_MAX;
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

@@ src/twsg_phase.sv @@
module twsg_phase
    import twsg_pkg::*;
#(
    parameter int TABLE_BITS = 10,
    parameter int INDEX_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IN_IDX_W-1:0]   in_index,
    input  logic [31:0]           phase_step,
    input  logic [CNT_W-1:0]      sample_count,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TABLE_BITS-1:0] out_addr,
    output logic                  out_last
);

    localparam int IDX_W = (INDEX_BITS < IN_IDX_W) ? INDEX_BITS : IN_IDX_W;

    logic [IDX_W-1:0]      idx_reg;
    logic                  last1_reg;
    logic                  vld1_reg;
    logic                  vld2_reg;
    logic [TABLE_BITS-1:0] addr_reg;
    logic                  last2_reg;
    logic [IDX_W-1:0]      idx_in;
    logic                  last_next;
    logic [31:0]           phase;
    logic                  rdy1;
    logic                  rdy2;

    // Each stage loads when it is empty or its content moves on.
    assign rdy2     = !vld2_reg || out_ready;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1;

    // Only the low index bits take part; the last mark compares the same bits.
    assign idx_in    = in_index[IDX_W-1:0];
    assign last_next = (sample_count != '0) &&
                       (CNT_W'(idx_in) == (sample_count - CNT_W'(1)));

    // Stage 1 captures the index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (rdy1) begin
            vld1_reg <= in_valid;
        end
        if (in_valid && rdy1) begin
            idx_reg   <= idx_in;
            last1_reg <= last_next;
        end
    end

    // Stage 2 forms the phase modulo one turn and keeps its top bits.
    assign phase = 32'(idx_reg) * phase_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (rdy2) begin
            vld2_reg <= vld1_reg;
        end
        if (vld1_reg && rdy2) begin
            addr_reg  <= phase[31 -: TABLE_BITS];
            last2_reg <= last1_reg;
        end
    end

    assign out_valid = vld2_reg;
    assign out_addr  = addr_reg;
    assign out_last  = last2_reg;

endmodule

@@ src/twsg_rom.sv @@
module twsg_rom
    import twsg_pkg::*;
#(
    parameter int TABLE_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TABLE_BITS-1:0] in_addr,
    input  logic                  in_last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output trig_t                 out_trig
);

    localparam int QLEN = 1 << (TABLE_BITS - 2);
    localparam int AW   = TABLE_BITS - 1;
    localparam logic [AW-1:0] QLEN_A = AW'(QLEN);

    logic [MAG_W-1:0]      rom_tbl [QLEN+1];
    logic [1:0]            quad;
    logic [1:0]            cquad;
    logic [TABLE_BITS-3:0] j;
    logic [AW-1:0]         s_idx;
    logic [AW-1:0]         c_idx;
    logic                  vld_reg;
    trig_t                 trig_reg;
    logic                  rdy;

    // Quarter-wave table, entries 0 through a quarter turn inclusive.
    for (genvar k = 0; k <= QLEN; k++) begin : g_rom
        assign rom_tbl[k] = rom_entry(k, TABLE_BITS);
    end

    // Fold the full-turn address into the quarter table; cosine is a quarter ahead.
    assign quad  = in_addr[TABLE_BITS-1 -: 2];
    assign cquad = quad + 2'd1;
    assign j     = in_addr[TABLE_BITS-3:0];
    assign s_idx = quad[0]  ? (QLEN_A - AW'(j)) : AW'(j);
    assign c_idx = cquad[0] ? (QLEN_A - AW'(j)) : AW'(j);

    assign rdy      = !vld_reg || out_ready;
    assign in_ready = rdy;

    // Registered read on both ports.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (rdy) begin
            vld_reg <= in_valid;
        end
        if (in_valid && rdy) begin
            trig_reg.s_neg <= quad[1];
            trig_reg.s_mag <= rom_tbl[s_idx];
            trig_reg.c_neg <= cquad[1];
            trig_reg.c_mag <= rom_tbl[c_idx];
            trig_reg.last  <= in_last;
        end
    end

    assign out_valid = vld_reg;
    assign out_trig  = trig_reg;

endmodule

@@ src/twsg_div.sv @@
module twsg_div
    import twsg_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  trig_t in_trig,
    output logic  out_valid,
    input  logic  out_ready,
    output tan_t  out_tan
);

    // Partial remainder, unconsumed dividend bits and quotient so far.
    typedef struct packed {
        logic [MAG_W:0]   rem;
        logic [QUO_W-1:0] dvd;
        logic [QUO_W-1:0] quo;
    } work_t;

    // A few restoring division steps, one quotient bit each.
    function automatic work_t div_steps(input work_t w_in, input logic [MAG_W-1:0] b);
        work_t        w;
        logic [MAG_W:0] r;
        w = w_in;
        for (int i = 0; i < DIV_STEPS; i++) begin
            r     = {w.rem[MAG_W-1:0], w.dvd[QUO_W-1]};
            w.dvd = {w.dvd[QUO_W-2:0], 1'b0};
            if (r >= {1'b0, b}) begin
                w.rem = r - {1'b0, b};
                w.quo = {w.quo[QUO_W-2:0], 1'b1};
            end else begin
                w.rem = r;
                w.quo = {w.quo[QUO_W-2:0], 1'b0};
            end
        end
        return w;
    endfunction

    logic                  vld_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] rdy;
    logic                  sat_reg  [DIV_STAGES];
    trig_t                 trig_reg [DIV_STAGES];
    work_t                 work_reg [DIV_STAGES];
    work_t                 work_init;
    logic                  sat_in;

    // Dividend is |sin| << 15. The quotient overflows the clamp exactly when
    // |sin| >= 256 * |cos|; otherwise it fits in the quotient bits and the
    // leading dividend bits start the remainder.
    assign sat_in        = {8'd0, in_trig.s_mag} >= {in_trig.c_mag, 8'd0};
    assign work_init.rem = (MAG_W+1)'(in_trig.s_mag[MAG_W-1:QUO_W-MAG_W]);
    assign work_init.dvd = {in_trig.s_mag[QUO_W-MAG_W-1:0], {MAG_W{1'b0}}};
    assign work_init.quo = '0;

    assign in_ready = rdy[0];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        if (k == DIV_STAGES - 1) begin : g_tail
            assign rdy[k] = !vld_reg[k] || out_ready;
        end else begin : g_body
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
        end

        if (k == 0) begin : g_head
            // First stage takes the operands straight from the ROM stage.
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (rdy[k]) begin
                    vld_reg[k] <= in_valid;
                end
                if (in_valid && rdy[k]) begin
                    trig_reg[k] <= in_trig;
                    sat_reg[k]  <= sat_in;
                    work_reg[k] <= div_steps(work_init, in_trig.c_mag);
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
                if (vld_reg[k-1] && rdy[k]) begin
                    trig_reg[k] <= trig_reg[k-1];
                    sat_reg[k]  <= sat_reg[k-1];
                    work_reg[k] <= div_steps(work_reg[k-1], trig_reg[k-1].c_mag);
                end
            end
        end
    end

    assign out_valid    = vld_reg[DIV_STAGES-1];
    assign out_tan.trig = trig_reg[DIV_STAGES-1];
    assign out_tan.sat  = sat_reg[DIV_STAGES-1];
    assign out_tan.quo  = work_reg[DIV_STAGES-1].quo;

endmodule

@@ src/trig_waveform_sample_gen.sv @@
// Channel   Handshake              Payload
// input     s_valid / s_ready      s_sample_index
// result    m_valid / m_ready      m_sample_value, m_pole_flag, m_last_sample
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample per clock is accepted and delivered while m_ready holds; a result
// passes, after its index is taken, two phase stages, the ROM read, six tangent
// divider stages (four quotient bits each), function select, amplitude multiply.
// Reset (aresetn low at a clock edge) empties the pipeline and loads the register
// defaults. Each stage holds while the next one is full and stalled, so empty
// stages still fill and the input keeps accepting while a result waits, until all are full.
module trig_waveform_sample_gen
    import twsg_pkg::*;
#(
    parameter int TABLE_BITS = 10,
    parameter int INDEX_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [IN_IDX_W-1:0]     s_sample_index,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_sample_value,
    output logic                    m_pole_flag,
    output logic                    m_last_sample
);

    logic [31:0]      phase_step_reg;
    logic [AMP_W-1:0] amplitude_reg;
    logic [1:0]       wave_func_reg;
    logic [CNT_W-1:0] sample_count_reg;

    logic                  ph_valid;
    logic                  ph_ready;
    logic [TABLE_BITS-1:0] ph_addr;
    logic                  ph_last;
    logic                  rom_valid;
    logic                  rom_ready;
    trig_t                 rom_trig;
    logic                  div_valid;
    logic                  div_ready;
    tan_t                  div_tan;

    logic                    sel_vld_reg;
    logic signed [VAL_W-1:0] sel_val_reg;
    logic                    sel_pole_reg;
    logic                    sel_last_reg;
    logic signed [VAL_W-1:0] val_next;
    logic                    pole_next;
    logic                    sel_rdy;

    logic                    out_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                    pole_reg;
    logic                    last_reg;
    logic signed [PROD_W:0]  prod_full;
    logic                    out_rdy;

    logic signed [VAL_W-1:0] s_val;
    logic signed [VAL_W-1:0] c_val;
    logic signed [VAL_W-1:0] q_val;
    logic                    s_nonneg;
    logic                    q_neg;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg   <= 32'd0;
            amplitude_reg    <= 16'd256;
            wave_func_reg    <= FUNC_SIN;
            sample_count_reg <= 17'd1024;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                REG_AMPLITUDE:    amplitude_reg    <= cfg_data[AMP_W-1:0];
                REG_WAVE_FUNC:    wave_func_reg    <= cfg_data[1:0];
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Phase computation and ROM address.
    twsg_phase #(
        .TABLE_BITS (TABLE_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_phase (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_index     (s_sample_index),
        .phase_step   (phase_step_reg),
        .sample_count (sample_count_reg),
        .out_valid    (ph_valid),
        .out_ready    (ph_ready),
        .out_addr     (ph_addr),
        .out_last     (ph_last)
    );

    // Sine and cosine lookup.
    twsg_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ph_valid),
        .in_ready  (ph_ready),
        .in_addr   (ph_addr),
        .in_last   (ph_last),
        .out_valid (rom_valid),
        .out_ready (rom_ready),
        .out_trig  (rom_trig)
    );

    // Tangent quotient.
    twsg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rom_valid),
        .in_ready  (rom_ready),
        .in_trig   (rom_trig),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_tan   (div_tan)
    );

    // Signed sine, cosine and quotient; a negative zero counts as zero.
    assign s_val    = div_tan.trig.s_neg ? -VAL_W'(div_tan.trig.s_mag)
                                         :  VAL_W'(div_tan.trig.s_mag);
    assign c_val    = div_tan.trig.c_neg ? -VAL_W'(div_tan.trig.c_mag)
                                         :  VAL_W'(div_tan.trig.c_mag);
    assign s_nonneg = !div_tan.trig.s_neg || (div_tan.trig.s_mag == '0);
    assign q_neg    = div_tan.trig.s_neg ^ div_tan.trig.c_neg;
    assign q_val    = q_neg ? -VAL_W'(div_tan.quo) : VAL_W'(div_tan.quo);

    // Pick the function value (zero for the unused code); tangent clamps at a pole or on overflow.
    always_comb begin
        val_next  = '0;
        pole_next = 1'b0;
        case (wave_func_reg)
            FUNC_SIN: val_next = s_val;
            FUNC_COS: val_next = c_val;
            FUNC_TAN: begin
                if (div_tan.trig.c_mag == '0) begin
                    val_next  = s_nonneg ? TAN_LIMIT : -TAN_LIMIT;
                    pole_next = 1'b1;
                end else if (div_tan.sat) begin
                    val_next  = q_neg ? -TAN_LIMIT : TAN_LIMIT;
                    pole_next = 1'b1;
                end else begin
                    val_next = q_val;
                end
            end
            default: begin
                val_next  = '0;
                pole_next = 1'b0;
            end
        endcase
    end

    assign out_rdy   = !out_vld_reg || m_ready;
    assign sel_rdy   = !sel_vld_reg || out_rdy;
    assign div_ready = sel_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_vld_reg <= 1'b0;
        end else if (sel_rdy) begin
            sel_vld_reg <= div_valid;
        end
        if (div_valid && sel_rdy) begin
            sel_val_reg  <= val_next;
            sel_pole_reg <= pole_next;
            sel_last_reg <= div_tan.trig.last;
        end
    end

    // Amplitude scaling into the output register; the final shift right by 8
    // is taken from the bit positions and rounds toward minus infinity.
    assign prod_full = $signed({1'b0, amplitude_reg}) * sel_val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_rdy) begin
            out_vld_reg <= sel_vld_reg;
        end
        if (sel_vld_reg && out_rdy) begin
            prod_reg <= prod_full[PROD_W-1:0];
            pole_reg <= sel_pole_reg;
            last_reg <= sel_last_reg;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_sample_value = prod_reg[PROD_W-1 -: OUT_W];
    assign m_pole_flag    = pole_reg;
    assign m_last_sample  = last_reg;

endmodule

@@ tb/sv/tb_trig_waveform_sample_gen.sv @@
`timescale 1ns / 1ps

module tb_trig_waveform_sample_gen;
    import twsg_pkg::*;

    // Address split of the ROM at the default table size.
    localparam int ADDR_W  = 10;
    localparam int QUARTER = 1 << (ADDR_W - 2);

    // Function code that selects nothing.
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam longint TAN_CLAMP  = 8388607;
    localparam int     IDLE_LIMIT = 2000;
    localparam int     RAND_SETS  = 10;
    localparam int     SET_ITEMS  = 95;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    pole;
        logic                    last;
    } sample_t;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    cfg_valid      = 1'b0;
    logic                    cfg_ready;
    logic [1:0]              cfg_index      = REG_PHASE_STEP;
    logic [31:0]             cfg_data       = '0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic [IN_IDX_W-1:0]     s_sample_index = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic signed [OUT_W-1:0] m_sample_value;
    logic                    m_pole_flag;
    logic                    m_last_sample;

    trig_waveform_sample_gen uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_index (s_sample_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_value (m_sample_value),
        .m_pole_flag    (m_pole_flag),
        .m_last_sample  (m_last_sample)
    );

    // Register copies that the predictor works from.
    logic [31:0]       step_reg;
    logic [AMP_W-1:0]  amp_reg;
    logic [1:0]        func_reg;
    logic [CNT_W-1:0]  count_reg;

    int                  quarter_wave [0:QUARTER];
    logic [IN_IDX_W-1:0] index_backlog [$];
    sample_t             pending_samples [$];

    bit calm      = 1'b0;
    int errors    = 0;
    int n_items   = 0;
    int n_samples = 0;
    int n_poles   = 0;
    int n_lasts   = 0;
    int n_setups  = 0;
    int send_gap  = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Quarter-wave entry k, from an eleven-term Taylor series in Q31, rounded to Q1.15.
    function automatic int quarter_sine(input int k);
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        x = (64'(k) * HALF_PI_Q31) >> (ADDR_W - 2);
        sum = x;
        term = x;
        for (int n = 1; n <= 10; n++) begin
            term = (term * x) >> 31;
            term = (term * x) >> 31;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - ((term <= sum) ? term : sum);
            end else begin
                sum = sum + term;
            end
        end
        v = (sum * 64'd32767 + (64'd1 << 30)) >> 31;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return int'(v);
    endfunction

    // Signed sine of a full-turn ROM address, unfolded from the quarter wave.
    function automatic longint sine_at(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-3:0] j;
        j = addr[ADDR_W-3:0];
        case (addr[ADDR_W-1:ADDR_W-2])
            2'd0:    return quarter_wave[j];
            2'd1:    return quarter_wave[QUARTER - j];
            2'd2:    return -quarter_wave[j];
            default: return -quarter_wave[QUARTER - j];
        endcase
    endfunction

    // Expected sample for one index under the current register settings.
    function automatic sample_t predict_sample(input logic [IN_IDX_W-1:0] idx);
        logic [31:0]       phase;
        logic [ADDR_W-1:0] addr;
        longint            s;
        longint            c;
        longint            val;
        longint            prod;
        sample_t           r;
        phase = idx * step_reg;
        addr = phase[31:32-ADDR_W];
        s = sine_at(addr);
        c = sine_at(ADDR_W'(addr + QUARTER));
        val = 0;
        r.pole = 1'b0;
        case (func_reg)
            FUNC_SIN: val = s;
            FUNC_COS: val = c;
            FUNC_TAN: begin
                if (c == 0) begin
                    val = (s >= 0) ? TAN_CLAMP : -TAN_CLAMP;
                    r.pole = 1'b1;
                end else begin
                    val = (s * 32768) / c;
                    if (val > TAN_CLAMP) begin
                        val = TAN_CLAMP;
                        r.pole = 1'b1;
                    end
                    if (val < -TAN_CLAMP) begin
                        val = -TAN_CLAMP;
                        r.pole = 1'b1;
                    end
                end
            end
            default: val = 0;
        endcase
        prod = longint'(amp_reg) * val;
        r.value = OUT_W'(prod >>> 8);
        r.last = (count_reg != '0) && ({1'b0, idx} == CNT_W'(count_reg - 1'b1));
        return r;
    endfunction

    // Blocks until every queued index is sent and every sample has come back.
    task automatic wait_drained();
        while (index_backlog.size() != 0 || s_valid || pending_samples.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // One register write transaction; valid is left high for a following write.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Loads all four registers once the block has gone quiet.
    task automatic configure(input logic [31:0] step, input logic [AMP_W-1:0] amp,
                             input logic [1:0] func, input logic [CNT_W-1:0] count);
        wait_drained();
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_AMPLITUDE, 32'(amp));
        write_reg(REG_WAVE_FUNC, 32'(func));
        write_reg(REG_SAMPLE_COUNT, 32'(count));
        cfg_valid <= 1'b0;
        step_reg  = step;
        amp_reg   = amp;
        func_reg  = func;
        count_reg = count;
        n_setups++;
    endtask

    // Driver: presents queued indices, with random gaps between transactions.
    always @(posedge aclk) begin
        logic next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                pending_samples.push_back(predict_sample(s_sample_index));
                void'(index_backlog.pop_front());
                n_items++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (index_backlog.size() != 0) begin
                    if (!calm && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 14) - 1;
                    end else begin
                        next_valid = 1'b1;
                        s_sample_index <= index_backlog[0];
                    end
                end
            end
            s_valid <= next_valid;
        end
    end

    // Monitor: checks each result transaction against the oldest expected sample.
    always @(posedge aclk) begin
        sample_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_samples++;
                if (m_pole_flag === 1'b1) begin
                    n_poles++;
                end
                if (m_last_sample === 1'b1) begin
                    n_lasts++;
                end
                if (pending_samples.size() == 0) begin
                    $error("result with no sample expected: value %0d", m_sample_value);
                    errors++;
                end else begin
                    want = pending_samples.pop_front();
                    if (m_sample_value !== want.value) begin
                        $error("sample_value: expected %0d, got %0d", want.value, m_sample_value);
                        errors++;
                    end
                    if (m_pole_flag !== want.pole) begin
                        $error("pole_flag: expected %0b, got %0b", want.pole, m_pole_flag);
                        errors++;
                    end
                    if (m_last_sample !== want.last) begin
                        $error("last_sample: expected %0b, got %0b", want.last, m_last_sample);
                        errors++;
                    end
                end
            end
            // Random stalls on the result side.
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[trig_waveform_sample_gen] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0]         step;
        logic [AMP_W-1:0]    amp;
        logic [1:0]          func;
        logic [CNT_W-1:0]    count;
        int                  left;
        int                  run;
        int                  start;

        for (int k = 0; k <= QUARTER; k++) begin
            quarter_wave[k] = quarter_sine(k);
        end
        step_reg  = '0;
        amp_reg   = 16'd256;
        func_reg  = FUNC_SIN;
        count_reg = 17'd1024;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Defaults after reset: zero step, so every sine is zero; 1023 ends the curve.
        index_backlog.push_back(16'd0);
        index_backlog.push_back(16'd1023);
        index_backlog.push_back(16'hFFFF);

        // One ROM entry per index: the quadrant corners of sine and both neighbours of zero.
        configure(32'h0040_0000, 16'd256, FUNC_SIN, 17'd1024);
        index_backlog.push_back(16'd1);
        index_backlog.push_back(16'd256);
        index_backlog.push_back(16'd512);
        index_backlog.push_back(16'd768);
        index_backlog.push_back(16'd1023);

        // Cosine at the first three quadrant corners.
        configure(32'h0040_0000, 16'd256, FUNC_COS, 17'd1024);
        index_backlog.push_back(16'd0);
        index_backlog.push_back(16'd256);
        index_backlog.push_back(16'd512);

        // Tangent at full gain: 45 and 225 degrees, both poles and the neighbours of the first.
        configure(32'h0040_0000, 16'hFFFF, FUNC_TAN, 17'd1024);
        index_backlog.push_back(16'd128);
        index_backlog.push_back(16'd256);
        index_backlog.push_back(16'd768);
        index_backlog.push_back(16'd255);
        index_backlog.push_back(16'd257);
        index_backlog.push_back(16'd640);

        // Unused function code, zero gain and a zero sample count.
        configure(32'hFFFF_FFFF, 16'd0, FUNC_NONE, 17'd0);
        index_backlog.push_back(16'hFFFF);
        index_backlog.push_back(16'd0);

        // Largest curve: the top index is its last sample.
        configure(32'hFFFF_FFFF, 16'hFFFF, FUNC_COS, 17'd65536);
        index_backlog.push_back(16'hFFFF);

        // One-sample curve, half-turn step; index 1 lies past the curve.
        configure(32'h8000_0000, 16'hFFFF, FUNC_SIN, 17'd1);
        index_backlog.push_back(16'd0);
        index_backlog.push_back(16'd1);

        // Random settings, mostly in-order runs within a curve; no idling at the end.
        for (int p = 0; p < RAND_SETS; p++) begin
            case ($urandom_range(0, 3))
                0:       count = CNT_W'($urandom_range(1, 64));
                1:       count = CNT_W'($urandom_range(1, 4096));
                2:       count = 17'd65536;
                default: count = ($urandom_range(0, 5) == 0) ? 17'd0
                                                             : CNT_W'($urandom_range(1, 1024));
            endcase
            case ($urandom_range(0, 3))
                0:       step = $urandom();
                1:       step = 32'h0040_0000 * $urandom_range(1, 16);
                2:       step = 32'($urandom_range(0, 255));
                default: step = (count == '0) ? $urandom() : 32'(64'h1_0000_0000 / count);
            endcase
            case ($urandom_range(0, 4))
                0:       amp = 16'hFFFF;
                1:       amp = 16'd256;
                default: amp = AMP_W'($urandom());
            endcase
            func = ($urandom_range(0, 9) == 0) ? FUNC_NONE : 2'($urandom_range(0, 2));
            calm = (p >= RAND_SETS - 2);
            configure(step, amp, func, count);
            left = SET_ITEMS;
            while (left > 0) begin
                run = $urandom_range(1, 40);
                if (run > left) begin
                    run = left;
                end
                if (count != '0 && $urandom_range(0, 3) != 0) begin
                    start = $urandom_range(0, int'(count) - 1);
                    for (int i = 0; i < run; i++) begin
                        index_backlog.push_back(IN_IDX_W'((start + i) % int'(count)));
                    end
                end else begin
                    for (int i = 0; i < run; i++) begin
                        index_backlog.push_back(IN_IDX_W'($urandom()));
                    end
                end
                left -= run;
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);

        $display("Sent %0d sample indices under %0d register settings.", n_items, n_setups);
        $display("Checked %0d samples: %0d with pole flag, %0d curve ends; %0d mismatches.",
                 n_samples, n_poles, n_lasts, errors);
        if (errors == 0) begin
            $display("[trig_waveform_sample_gen] OK");
        end else begin
            $display("[trig_waveform_sample_gen] ERROR");
        end
        $finish;
    end

endmodule
